// ----- design/sgr_escape_to_style_events_defines.svh -----
// Assertion macros used by the checker file.
`ifndef SGR_ESCAPE_TO_STYLE_EVENTS_DEFINES_SVH
`define SGR_ESCAPE_TO_STYLE_EVENTS_DEFINES_SVH

// Same-cycle implication.
`define SGR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sgr check failed");

// Next-cycle implication.
`define SGR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sgr check failed");

`endif

// ----- design/sgr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sgr_pkg;

  localparam int MAX_ATTRS_DEF = 32;
  localparam int QUEUE_DEPTH_DEF = 4;
  // Index field width covering the whole MAX_ATTRS range (up to 64)
  localparam int IDX_MAX_W = 6;

  localparam int CHAR_W = 21;
  localparam int IN_TDATA_W = 24;
  localparam int OUT_TDATA_W = 32;

  localparam logic [CHAR_W-1:0] CH_ESC      = 21'h1B;
  localparam logic [CHAR_W-1:0] CH_LBRACKET = 21'h5B;
  localparam logic [CHAR_W-1:0] CH_SEMI     = 21'h3B;
  localparam logic [CHAR_W-1:0] CH_M        = 21'h6D;
  localparam logic [CHAR_W-1:0] CH_H        = 21'h68;
  localparam logic [CHAR_W-1:0] CH_L        = 21'h6C;
  localparam logic [CHAR_W-1:0] CH_ZERO     = 21'h30;
  localparam logic [CHAR_W-1:0] CH_NINE     = 21'h39;

  typedef enum logic [3:0] {
    EV_CHAR      = 4'd0,
    EV_CLOSE     = 4'd1,
    EV_OPEN      = 4'd2,
    EV_REOPEN    = 4'd3,
    EV_BOLD      = 4'd4,
    EV_FG        = 4'd5,
    EV_BG        = 4'd6,
    EV_IGNORED   = 4'd7,
    EV_BAD_COLOR = 4'd8,
    EV_TOO_MANY  = 4'd9,
    EV_BAD_ESC   = 4'd10
  } event_kind_t;

  typedef enum logic [2:0] {
    CLS_LITERAL = 3'd0,
    CLS_LT      = 3'd1,
    CLS_GT      = 3'd2,
    CLS_AMP     = 3'd3,
    CLS_APOS    = 3'd4,
    CLS_QUOTE   = 3'd5,
    CLS_NUMERIC = 3'd6
  } esc_class_t;

  typedef struct packed {
    logic                 is_style;
    event_kind_t          kind;
    logic [CHAR_W-1:0]    ch;
    esc_class_t           cls;
    logic                 lone_zero;
    logic [IDX_MAX_W-1:0] last_idx;
  } q_item_t;

  typedef struct packed {
    logic                 en;
    logic [IDX_MAX_W-1:0] addr;
    logic [7:0]           data;
  } store_wr_t;

  function automatic esc_class_t class_of(input logic [CHAR_W-1:0] c);
    esc_class_t r;
    r = CLS_LITERAL;
    if (c == 21'h3C) r = CLS_LT;
    else if (c == 21'h3E) r = CLS_GT;
    else if (c == 21'h26) r = CLS_AMP;
    else if (c == 21'h27) r = CLS_APOS;
    else if (c == 21'h22) r = CLS_QUOTE;
    else if ((c >= 21'h01 && c <= 21'h08) || c == 21'h0B || c == 21'h0C ||
             (c >= 21'h0E && c <= 21'h1F) || c == 21'h7F ||
             (c >= 21'h80 && c <= 21'h84) || (c >= 21'h86 && c <= 21'h9F))
      r = CLS_NUMERIC;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/sgr_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sgr_front #(
  parameter int MAX_ATTRS = sgr_pkg::MAX_ATTRS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic [sgr_pkg::CHAR_W-1:0] in_char,
  output logic                            in_ready,
  output logic                            q_push,
  output sgr_pkg::q_item_t                q_item,
  input  wire logic                       q_full,
  input  wire logic                       style_done,
  output sgr_pkg::store_wr_t              store_wr
);

  localparam int AW = $clog2(MAX_ATTRS);
  localparam int CW = AW + 1;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESC    = 2'd1,
    MODE_ATTR   = 2'd2
  } mode_t;

  mode_t          mode_r, mode_nxt;
  logic [AW-1:0]  count_r, count_nxt;
  logic [7:0]     acc_r, acc_nxt;
  logic           pend_r, pend_nxt;

  logic           accept;
  logic [CW-1:0]  cnt_inc;
  logic           store_full;
  logic [11:0]    acc_x10;
  logic [7:0]     acc_sat;
  logic           is_digit;

  assign in_ready   = !pend_r && !q_full;
  assign accept     = in_valid && in_ready;
  assign cnt_inc    = {1'b0, count_r} + CW'(1);
  assign store_full = cnt_inc >= CW'(MAX_ATTRS);
  assign is_digit   = in_char >= sgr_pkg::CH_ZERO && in_char <= sgr_pkg::CH_NINE;
  // acc*10 + digit; the low nibble of '0'..'9' is the digit value
  assign acc_x10    = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + {8'b0, in_char[3:0]};
  assign acc_sat    = (acc_x10 > 12'd255) ? 8'hFF : acc_x10[7:0];

  always_comb begin
    mode_nxt  = mode_r;
    count_nxt = count_r;
    acc_nxt   = acc_r;
    pend_nxt  = pend_r;
    q_push    = 1'b0;
    q_item.is_style  = 1'b0;
    q_item.kind      = sgr_pkg::EV_CHAR;
    q_item.ch        = '0;
    q_item.cls       = sgr_pkg::CLS_LITERAL;
    q_item.lone_zero = 1'b0;
    q_item.last_idx  = sgr_pkg::IDX_MAX_W'(count_r);
    store_wr.en   = 1'b0;
    store_wr.addr = sgr_pkg::IDX_MAX_W'(count_r);
    store_wr.data = acc_r;

    if (style_done) pend_nxt = 1'b0;

    if (accept) begin
      if (in_char == sgr_pkg::CH_ESC) begin
        mode_nxt  = MODE_ESC;
        count_nxt = '0;
        acc_nxt   = '0;
      end else begin
        case (mode_r)
          MODE_ESC: begin
            if (in_char == sgr_pkg::CH_LBRACKET) begin
              mode_nxt = MODE_ATTR;
            end else begin
              q_push      = 1'b1;
              q_item.kind = sgr_pkg::EV_BAD_ESC;
              mode_nxt    = MODE_NORMAL;
            end
          end
          MODE_ATTR: begin
            if (in_char == sgr_pkg::CH_SEMI) begin
              if (store_full) begin
                q_push      = 1'b1;
                q_item.kind = sgr_pkg::EV_TOO_MANY;
                mode_nxt    = MODE_NORMAL;
              end else begin
                store_wr.en = 1'b1;
                count_nxt   = cnt_inc[AW-1:0];
                acc_nxt     = '0;
              end
            end else if (in_char == sgr_pkg::CH_M) begin
              q_push   = 1'b1;
              mode_nxt = MODE_NORMAL;
              if (store_full) begin
                q_item.kind = sgr_pkg::EV_TOO_MANY;
              end else begin
                store_wr.en      = 1'b1;
                q_item.is_style  = 1'b1;
                q_item.lone_zero = (count_r == '0) && (acc_r == 8'd0);
                pend_nxt         = 1'b1;
              end
            end else if (is_digit) begin
              acc_nxt = acc_sat;
            end else if (in_char == sgr_pkg::CH_H || in_char == sgr_pkg::CH_L) begin
              q_push      = 1'b1;
              q_item.kind = sgr_pkg::EV_BAD_ESC;
              mode_nxt    = MODE_NORMAL;
            end
          end
          default: begin
            q_push      = 1'b1;
            q_item.kind = sgr_pkg::EV_CHAR;
            q_item.ch   = in_char;
            q_item.cls  = sgr_pkg::class_of(in_char);
            mode_nxt    = MODE_NORMAL;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_NORMAL;
      count_r <= '0;
      acc_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      count_r <= count_nxt;
      acc_r   <= acc_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/sgr_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sgr_fifo #(
  parameter int DEPTH = sgr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  sgr_pkg::q_item_t       push_item,
  output logic                   full,
  input  wire logic              pop,
  output logic                   valid,
  output sgr_pkg::q_item_t       head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  sgr_pkg::q_item_t entries [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] fill_r, fill_nxt;

  assign full  = fill_r == NW'(DEPTH);
  assign valid = fill_r != '0;
  assign head  = entries[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    if (push && !pop)      fill_nxt = fill_r + NW'(1);
    else if (pop && !push) fill_nxt = fill_r - NW'(1);
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr_r] <= push_item;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- design/sgr_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sgr_back #(
  parameter int MAX_ATTRS = sgr_pkg::MAX_ATTRS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       q_valid,
  input  sgr_pkg::q_item_t                q_item,
  output logic                            q_pop,
  input  sgr_pkg::store_wr_t              store_wr,
  output logic                            style_done,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output sgr_pkg::event_kind_t            out_kind,
  output logic [sgr_pkg::CHAR_W-1:0]      out_char,
  output sgr_pkg::esc_class_t             out_cls,
  output logic [2:0]                      out_color,
  output logic                            out_last
);

  localparam int AW = $clog2(MAX_ATTRS);

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_ATTR = 1'b1
  } state_t;

  state_t                    state_r, state_nxt;
  logic                      span_open_r, span_open_nxt;
  logic [AW-1:0]             idx_r, idx_nxt;
  logic [AW-1:0]             last_idx_r, last_idx_nxt;
  logic                      out_valid_r, out_valid_nxt;
  sgr_pkg::event_kind_t      kind_r, kind_nxt;
  logic [sgr_pkg::CHAR_W-1:0] char_r, char_nxt;
  sgr_pkg::esc_class_t       cls_r, cls_nxt;
  logic [2:0]                color_r, color_nxt;
  logic                      last_r, last_nxt;

  logic [7:0]    attr_mem [MAX_ATTRS];
  logic [7:0]    rdata_r;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          load;
  sgr_pkg::event_kind_t attr_kind;
  logic [2:0]    attr_color;
  logic [7:0]    fg_off, bg_off;

  assign out_valid = out_valid_r;
  assign out_kind  = kind_r;
  assign out_char  = char_r;
  assign out_cls   = cls_r;
  assign out_color = color_r;
  assign out_last  = last_r;
  assign load      = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (store_wr.en) attr_mem[store_wr.addr[AW-1:0]] <= store_wr.data;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rdata_r <= attr_mem[rd_addr];
  end

  // attribute number -> event
  assign fg_off = rdata_r - 8'd30;
  assign bg_off = rdata_r - 8'd40;
  always_comb begin
    attr_kind  = sgr_pkg::EV_IGNORED;
    attr_color = '0;
    if (rdata_r == 8'd1) begin
      attr_kind = sgr_pkg::EV_BOLD;
    end else if (rdata_r >= 8'd30 && rdata_r <= 8'd37) begin
      attr_kind  = sgr_pkg::EV_FG;
      attr_color = fg_off[2:0];
    end else if (rdata_r >= 8'd40 && rdata_r <= 8'd47) begin
      attr_kind  = sgr_pkg::EV_BG;
      attr_color = bg_off[2:0];
    end else if (rdata_r == 8'd38 || rdata_r == 8'd39 ||
                 rdata_r == 8'd48 || rdata_r == 8'd49) begin
      attr_kind = sgr_pkg::EV_BAD_COLOR;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    span_open_nxt = span_open_r;
    idx_nxt       = idx_r;
    last_idx_nxt  = last_idx_r;
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    char_nxt      = char_r;
    cls_nxt       = cls_r;
    color_nxt     = color_r;
    last_nxt      = last_r;
    q_pop         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = idx_r;
    style_done    = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (load) begin
          out_valid_nxt = 1'b0;
          if (q_valid) begin
            q_pop         = 1'b1;
            out_valid_nxt = 1'b1;
            color_nxt     = '0;
            if (!q_item.is_style) begin
              kind_nxt = q_item.kind;
              char_nxt = q_item.ch;
              cls_nxt  = q_item.cls;
              last_nxt = 1'b1;
            end else begin
              char_nxt = '0;
              cls_nxt  = sgr_pkg::CLS_LITERAL;
              if (q_item.lone_zero && span_open_r) begin
                kind_nxt      = sgr_pkg::EV_CLOSE;
                last_nxt      = 1'b1;
                span_open_nxt = 1'b0;
                style_done    = 1'b1;
              end else begin
                kind_nxt      = span_open_r ? sgr_pkg::EV_REOPEN : sgr_pkg::EV_OPEN;
                last_nxt      = 1'b0;
                span_open_nxt = 1'b1;
                rd_en         = 1'b1;
                rd_addr       = '0;
                idx_nxt       = '0;
                last_idx_nxt  = q_item.last_idx[AW-1:0];
                state_nxt     = ST_ATTR;
              end
            end
          end
        end
      end
      ST_ATTR: begin
        if (load) begin
          out_valid_nxt = 1'b1;
          kind_nxt      = attr_kind;
          char_nxt      = '0;
          cls_nxt       = sgr_pkg::CLS_LITERAL;
          color_nxt     = attr_color;
          last_nxt      = idx_r == last_idx_r;
          if (idx_r == last_idx_r) begin
            state_nxt  = ST_IDLE;
            style_done = 1'b1;
          end else begin
            idx_nxt = idx_r + AW'(1);
            rd_en   = 1'b1;
            rd_addr = idx_r + AW'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      span_open_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      span_open_r <= span_open_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r      <= idx_nxt;
    last_idx_r <= last_idx_nxt;
    kind_r     <= kind_nxt;
    char_r     <= char_nxt;
    cls_r      <= cls_nxt;
    color_r    <= color_nxt;
    last_r     <= last_nxt;
  end

endmodule

`default_nettype wire

// ----- design/sgr_escape_to_style_events.sv -----
`timescale 1ns / 1ps
`default_nettype none

// ANSI SGR parser: one code point per input beat. Plain text passes through as
// char events at one beat per cycle while the output is not stalled. In an
// escape, ESC, '[', digits and ';' produce nothing unless ';' finds the store
// full. A closing 'm' holds off further input until its last event has been
// loaded into the output register: a close event, or a span event plus one
// event per stored attribute, one per cycle unless the output stalls, paced by
// the single read port of the attribute store. Errors are single events. The
// event kind travels on tuser, and each beat's final event carries tlast.
module sgr_escape_to_style_events #(
  parameter int MAX_ATTRS   = sgr_pkg::MAX_ATTRS_DEF,
  parameter int QUEUE_DEPTH = sgr_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [sgr_pkg::IN_TDATA_W-1:0]  in_tdata,   // [20:0] char_code
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // [20:0] out_char, [23:21] escape_class, [26:24] color_index
  output logic [sgr_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic [3:0]                           out_tuser,  // [3:0] event_kind
  output logic                                 out_tlast
);

  sgr_pkg::q_item_t     push_item, head_item;
  sgr_pkg::store_wr_t   store_wr;
  sgr_pkg::event_kind_t ev_kind;
  sgr_pkg::esc_class_t  ev_cls;
  logic [sgr_pkg::CHAR_W-1:0] ev_char;
  logic [2:0] ev_color;
  logic push, full, pop, q_valid, style_done;

  sgr_front #(.MAX_ATTRS(MAX_ATTRS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_char    (in_tdata[sgr_pkg::CHAR_W-1:0]),
    .in_ready   (in_tready),
    .q_push     (push),
    .q_item     (push_item),
    .q_full     (full),
    .style_done (style_done),
    .store_wr   (store_wr)
  );

  sgr_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .valid     (q_valid),
    .head      (head_item)
  );

  sgr_back #(.MAX_ATTRS(MAX_ATTRS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_item     (head_item),
    .q_pop      (pop),
    .store_wr   (store_wr),
    .style_done (style_done),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_kind   (ev_kind),
    .out_char   (ev_char),
    .out_cls    (ev_cls),
    .out_color  (ev_color),
    .out_last   (out_tlast)
  );

  assign out_tdata = {5'b0, ev_color, ev_cls, ev_char};
  assign out_tuser = ev_kind;

endmodule

`default_nettype wire

// ----- design/sgr_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "sgr_escape_to_style_events_defines.svh"

module sgr_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [23:0] in_tdata,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [31:0] out_tdata,
  input wire logic [3:0]  out_tuser,
  input wire logic        out_tlast
);

  logic [3:0]  kind;
  logic        in_beat;
  logic        out_beat;
  logic        out_stall;
  logic        single_kind;
  logic        open_kind;
  logic [36:0] out_bus;
  assign kind        = out_tuser;
  assign in_beat     = in_tvalid && in_tready && (in_tdata[20:0] != '0);
  assign out_beat    = out_tvalid && out_tready;
  assign out_stall   = out_tvalid && !out_tready;
  assign out_bus     = {out_tdata, out_tuser, out_tlast};
  assign single_kind = kind == sgr_pkg::EV_CHAR || kind == sgr_pkg::EV_CLOSE ||
                       kind == sgr_pkg::EV_TOO_MANY || kind == sgr_pkg::EV_BAD_ESC;
  assign open_kind   = kind == sgr_pkg::EV_OPEN || kind == sgr_pkg::EV_REOPEN;

  // stalled result beat holds
  `SGR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_tvalid && $stable(out_bus))

  // characters, closes and errors are always the only event of their beat
  `SGR_ASSERT_SAME(a_single_last, clk, rst_n, out_tvalid && single_kind, out_tlast)

  // a span open is always followed by at least one attribute event
  `SGR_ASSERT_SAME(a_open_not_last, clk, rst_n, out_tvalid && open_kind, !out_tlast)

  // right after a non-final event, no plain character can show
  `SGR_ASSERT_NEXT(a_no_char_mid_run, clk, rst_n, out_beat && !out_tlast, !(out_tvalid && kind == sgr_pkg::EV_CHAR))

  // input stays blocked while a style run is still being sent
  `SGR_ASSERT_SAME(a_no_input_mid_run, clk, rst_n, out_tvalid && !out_tlast && in_beat, 1'b0)

endmodule

bind sgr_escape_to_style_events sgr_checker u_sgr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

`default_nettype wire
